// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/jst_pkg.sv
// ----------------------------------------------------------------------------
// JSON stream tokenizer package
// Types, codes and constant tables shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package jst_pkg;

  localparam int DEFAULT_MAX_DEPTH = 32;
  localparam logic [5:0] DEPTH_LIMIT_RESET = 6'd32;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_doc;
  } jst_in_t;

  typedef struct packed {
    logic [3:0]  event_res;
    logic [7:0]  data_byte;
    logic        number_done;
    logic [5:0]  nest_depth;
    logic [2:0]  error_code;
    logic [15:0] line_number;
    logic        doc_done;
    logic        unbalanced;
  } jst_out_t;

  typedef struct packed {
    logic [6:0]  expect_mask;
    logic [2:0]  mode;
    logic        in_obj;
    logic        in_key;
    logic        in_arr;
    logic [2:0]  lit_pos;
    logic        esc;
    logic [2:0]  err;
    logic [15:0] line;
  } jst_state_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
    logic push_obj;
  } jst_stack_op_t;

  localparam logic [6:0] EX_ARR     = 7'h01;
  localparam logic [6:0] EX_OBJ     = 7'h02;
  localparam logic [6:0] EX_VAL     = 7'h04;
  localparam logic [6:0] EX_COMMA   = 7'h08;
  localparam logic [6:0] EX_COLON   = 7'h10;
  localparam logic [6:0] EX_ARR_END = 7'h20;
  localparam logic [6:0] EX_OBJ_END = 7'h40;

  localparam logic [2:0] M_IDLE  = 3'd0;
  localparam logic [2:0] M_STR   = 3'd1;
  localparam logic [2:0] M_KEY   = 3'd2;
  localparam logic [2:0] M_NUM   = 3'd3;
  localparam logic [2:0] M_TRUE  = 3'd4;
  localparam logic [2:0] M_FALSE = 3'd5;
  localparam logic [2:0] M_NULL  = 3'd6;

  localparam logic [3:0] EV_NONE    = 4'd0;
  localparam logic [3:0] EV_ARR_OPN = 4'd1;
  localparam logic [3:0] EV_ARR_CLS = 4'd2;
  localparam logic [3:0] EV_OBJ_OPN = 4'd3;
  localparam logic [3:0] EV_OBJ_CLS = 4'd4;
  localparam logic [3:0] EV_COMMA   = 4'd5;
  localparam logic [3:0] EV_COLON   = 4'd6;
  localparam logic [3:0] EV_KEYBYTE = 4'd7;
  localparam logic [3:0] EV_KEYEND  = 4'd8;
  localparam logic [3:0] EV_STRBYTE = 4'd9;
  localparam logic [3:0] EV_STREND  = 4'd10;
  localparam logic [3:0] EV_NUMBYTE = 4'd11;
  localparam logic [3:0] EV_TRUE    = 4'd12;

  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_CHAR    = 3'd1;
  localparam logic [2:0] ERR_TOKEN   = 3'd2;
  localparam logic [2:0] ERR_LITERAL = 3'd3;
  localparam logic [2:0] ERR_ESCAPE  = 3'd4;
  localparam logic [2:0] ERR_SEP     = 3'd5;
  localparam logic [2:0] ERR_DEPTH   = 3'd6;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LC_B  = 8'h62;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_N  = 8'h6E;
  localparam logic [7:0] CH_LC_R  = 8'h72;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  function automatic logic [7:0] lit_char(input logic [1:0] which, input logic [2:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    case ({which, pos})
      5'b00_000: ch = "t";
      5'b00_001: ch = "r";
      5'b00_010: ch = "u";
      5'b00_011: ch = "e";
      5'b01_000: ch = "f";
      5'b01_001: ch = "a";
      5'b01_010: ch = "l";
      5'b01_011: ch = "s";
      5'b01_100: ch = "e";
      5'b10_000: ch = "n";
      5'b10_001: ch = "u";
      5'b10_010: ch = "l";
      5'b10_011: ch = "l";
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [2:0] lit_len(input logic [1:0] which);
    return (which == 2'd1) ? 3'd5 : 3'd4;
  endfunction

endpackage

`default_nettype wire

// File: rtl/jst_stack.sv
// ----------------------------------------------------------------------------
// Container stack
// Shift-register stack of array or object marks, top entry at position zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jst_stack
  import jst_pkg::*;
#(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire jst_stack_op_t op,
  output logic               top_obj,
  output logic               below_obj
);

  logic [MAX_DEPTH-1:0] stk_r;
  logic [MAX_DEPTH-1:0] stk_nxt;

  always_comb begin
    stk_nxt = stk_r;
    if (op.clear) begin
      stk_nxt = '0;
    end else if (op.push) begin
      stk_nxt = {stk_r[MAX_DEPTH-2:0], op.push_obj};
    end else if (op.pop) begin
      stk_nxt = {1'b0, stk_r[MAX_DEPTH-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stk_r <= '0;
    end else if (en) begin
      stk_r <= stk_nxt;
    end
  end

  assign top_obj   = stk_r[0];
  assign below_obj = stk_r[1];

endmodule

`default_nettype wire

// File: rtl/jst_step.sv
// ----------------------------------------------------------------------------
// Tokenizer step logic
// Next-state and token event for one document byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module jst_step
  import jst_pkg::*;
#(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH,
  parameter int LW = $clog2(MAX_DEPTH + 1)
) (
  input  wire jst_state_t    st,
  input  wire logic [LW-1:0] level,
  input  wire logic          top_obj,
  input  wire logic          below_obj,
  input  wire logic [5:0]    depth_limit,
  input  wire jst_in_t       word,
  output jst_state_t         st_nxt,
  output logic [LW-1:0]      level_nxt,
  output jst_stack_op_t      op,
  output jst_out_t           res
);

  localparam int CW = (LW > 6) ? LW : 6;
  localparam logic [CW-1:0] MAX_EXT = CW'(MAX_DEPTH);

  logic [CW-1:0] lim;

  always_comb begin
    lim = (CW'(depth_limit) > MAX_EXT) ? MAX_EXT : CW'(depth_limit);
  end

  always_comb begin
    logic [7:0] c;
    logic [7:0] d;
    logic [3:0] ev;
    logic [7:0] data;
    logic       nd;
    logic       do_idle;
    logic       key;
    logic       tob;
    logic       is_digit;
    logic       is_term;
    logic [1:0] which;
    logic [2:0] pos1;
    logic       obj;

    st_nxt    = st;
    level_nxt = level;
    op        = '0;
    ev        = EV_NONE;
    data      = 8'h00;
    nd        = 1'b0;
    do_idle   = 1'b0;
    d         = 8'h00;
    obj       = 1'b0;
    c         = word.end_of_doc ? CH_LF : word.in_byte;
    key       = (st.mode == M_KEY);
    tob       = (level != '0) && top_obj;
    is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
    is_term   = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
                (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_LBRC) || (c == CH_RBRC) ||
                (c == CH_COLON) || (c == CH_COMMA);
    which     = 2'(st.mode - M_TRUE);
    pos1      = st.lit_pos + 3'd1;

    if (st.err == ERR_NONE) begin
      if (st.mode == M_STR || st.mode == M_KEY) begin
        if (st.esc) begin
          case (c)
            CH_QUOTE, CH_BSL, CH_SLASH: d = c;
            CH_LC_B: d = 8'h08;
            CH_LC_F: d = 8'h0C;
            CH_LC_N: d = 8'h0A;
            CH_LC_R: d = 8'h0D;
            CH_LC_T: d = 8'h09;
            default: st_nxt.err = ERR_ESCAPE;
          endcase
          if (st_nxt.err == ERR_NONE) begin
            st_nxt.esc = 1'b0;
            ev   = key ? EV_KEYBYTE : EV_STRBYTE;
            data = d;
          end
        end else if (c == CH_BSL) begin
          st_nxt.esc = 1'b1;
        end else if (c == CH_QUOTE) begin
          st_nxt.mode = M_IDLE;
          ev = key ? EV_KEYEND : EV_STREND;
          if (st.in_key) begin
            st_nxt.expect_mask = EX_COLON;
            st_nxt.in_key = 1'b0;
          end else if (level == '0) begin
            st_nxt.expect_mask = '0;
          end else begin
            st_nxt.expect_mask = EX_COMMA | (tob ? EX_OBJ_END : EX_ARR_END);
          end
        end else begin
          ev   = key ? EV_KEYBYTE : EV_STRBYTE;
          data = c;
        end
      end else if (st.mode == M_NUM) begin
        if (is_digit) begin
          st_nxt.lit_pos = 3'd1;
          ev   = EV_NUMBYTE;
          data = c;
        end else if (is_term) begin
          if (st.lit_pos == 3'd0) begin
            st_nxt.err = ERR_CHAR;
          end else begin
            nd = 1'b1;
            st_nxt.mode = M_IDLE;
            st_nxt.lit_pos = 3'd0;
            if (st.in_key) begin
              st_nxt.expect_mask = EX_COLON;
              st_nxt.in_key = 1'b0;
            end else if (level == '0) begin
              st_nxt.expect_mask = '0;
            end else begin
              st_nxt.expect_mask = EX_COMMA | (tob ? EX_OBJ_END : EX_ARR_END);
            end
            do_idle = 1'b1;
          end
        end else begin
          st_nxt.err = ERR_CHAR;
        end
      end else if (st.mode >= M_TRUE && st.mode <= M_NULL) begin
        if (st.lit_pos >= lit_len(which) || lit_char(which, st.lit_pos) != c) begin
          st_nxt.err = ERR_LITERAL;
        end else begin
          st_nxt.lit_pos = pos1;
          if (pos1 == lit_len(which)) begin
            ev = EV_TRUE + {2'b00, which};
            st_nxt.mode = M_IDLE;
            st_nxt.lit_pos = 3'd0;
            if (st.in_key) begin
              st_nxt.expect_mask = EX_COLON;
              st_nxt.in_key = 1'b0;
            end else if (level == '0) begin
              st_nxt.expect_mask = '0;
            end else begin
              st_nxt.expect_mask = EX_COMMA | (tob ? EX_OBJ_END : EX_ARR_END);
            end
          end
        end
      end else begin
        do_idle = 1'b1;
      end

      if (do_idle) begin
        case (c)
          CH_SPACE, CH_TAB, CH_CR: begin
          end
          CH_LF: begin
            if (st.line != 16'hFFFF) begin
              st_nxt.line = st.line + 16'd1;
            end
          end
          CH_LBRK, CH_LBRC: begin
            obj = (c == CH_LBRC);
            if ((st_nxt.expect_mask & (obj ? EX_OBJ : EX_ARR)) == '0) begin
              st_nxt.err = ERR_TOKEN;
            end else if (CW'(level) >= lim) begin
              st_nxt.err = ERR_DEPTH;
            end else begin
              op.push     = 1'b1;
              op.push_obj = obj;
              level_nxt   = level + 1'b1;
              st_nxt.in_obj = obj;
              st_nxt.in_arr = !obj;
              st_nxt.in_key = obj;
              st_nxt.expect_mask = obj ? (EX_VAL | EX_OBJ_END) :
                                         (EX_VAL | EX_ARR | EX_OBJ | EX_ARR_END);
              ev = obj ? EV_OBJ_OPN : EV_ARR_OPN;
            end
          end
          CH_RBRK, CH_RBRC: begin
            obj = (c == CH_RBRC);
            if ((st_nxt.expect_mask & (obj ? EX_OBJ_END : EX_ARR_END)) == '0 ||
                level == '0) begin
              st_nxt.err = ERR_TOKEN;
            end else begin
              op.pop    = 1'b1;
              level_nxt = level - 1'b1;
              st_nxt.in_key = 1'b0;
              if (level == LW'(1)) begin
                st_nxt.in_obj = 1'b0;
                st_nxt.in_arr = 1'b0;
                st_nxt.expect_mask = '0;
              end else begin
                st_nxt.in_obj = below_obj;
                st_nxt.in_arr = !below_obj;
                st_nxt.expect_mask = EX_COMMA | (below_obj ? EX_OBJ_END : EX_ARR_END);
              end
              ev = obj ? EV_OBJ_CLS : EV_ARR_CLS;
            end
          end
          CH_COMMA: begin
            if (!st_nxt.in_arr && !st_nxt.in_obj) begin
              st_nxt.err = ERR_SEP;
            end else if ((st_nxt.expect_mask & EX_COMMA) == '0) begin
              st_nxt.err = ERR_TOKEN;
            end else begin
              if (st_nxt.in_arr) begin
                st_nxt.expect_mask = EX_VAL | EX_ARR | EX_OBJ;
              end else begin
                st_nxt.expect_mask = EX_VAL | EX_OBJ_END;
                st_nxt.in_key = 1'b1;
              end
              ev = EV_COMMA;
            end
          end
          CH_COLON: begin
            if ((st_nxt.expect_mask & EX_COLON) == '0) begin
              st_nxt.err = ERR_TOKEN;
            end else begin
              st_nxt.expect_mask = EX_VAL | EX_ARR | EX_OBJ;
              st_nxt.in_key = 1'b0;
              ev = EV_COLON;
            end
          end
          CH_QUOTE: begin
            if ((st_nxt.expect_mask & EX_VAL) == '0) begin
              st_nxt.err = ERR_TOKEN;
            end else begin
              st_nxt.mode = st_nxt.in_key ? M_KEY : M_STR;
              st_nxt.esc = 1'b0;
            end
          end
          CH_LC_T, CH_LC_F, CH_LC_N: begin
            if ((st_nxt.expect_mask & EX_VAL) == '0 || st_nxt.in_key) begin
              st_nxt.err = ERR_TOKEN;
            end else begin
              st_nxt.mode = (c == CH_LC_T) ? M_TRUE : ((c == CH_LC_F) ? M_FALSE : M_NULL);
              st_nxt.lit_pos = 3'd1;
            end
          end
          default: begin
            if (c == CH_MINUS || is_digit) begin
              if ((st_nxt.expect_mask & EX_VAL) == '0 || st_nxt.in_key) begin
                st_nxt.err = ERR_TOKEN;
              end else begin
                st_nxt.mode = M_NUM;
                st_nxt.lit_pos = (c == CH_MINUS) ? 3'd0 : 3'd1;
                ev   = EV_NUMBYTE;
                data = c;
              end
            end else begin
              st_nxt.err = ERR_CHAR;
            end
          end
        endcase
      end
    end

    if (st_nxt.err != ERR_NONE) begin
      ev   = EV_NONE;
      data = 8'h00;
    end

    res.event_res   = ev;
    res.data_byte   = data;
    res.number_done = nd;
    res.nest_depth  = 6'(level_nxt);
    res.error_code  = st_nxt.err;
    res.line_number = st_nxt.line;
    res.doc_done    = word.end_of_doc;
    res.unbalanced  = word.end_of_doc && (level_nxt != '0);

    if (word.end_of_doc) begin
      st_nxt = '{expect_mask: EX_ARR | EX_OBJ | EX_VAL, mode: M_IDLE, in_obj: 1'b0,
                 in_key: 1'b0, in_arr: 1'b0, lit_pos: 3'd0, esc: 1'b0,
                 err: ERR_NONE, line: 16'd1};
      level_nxt = '0;
      op.clear  = 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/json_stream_tokenizer_core.sv
// ----------------------------------------------------------------------------
// JSON stream tokenizer core
// Byte-wide JSON tokenizer and validator with a container stack.
// ----------------------------------------------------------------------------
// One document word enters per cycle while the output is not stalled, and
// yields one token word. A word is captured in the input register, decoded by
// the step logic against the tokenizer state and the top two stack entries once
// the output register is free, and its result is held in the output register;
// the sustained rate is one word per clock while out_ready stays high. The
// whole state, including the stack, is updated in the same cycle as the result
// is registered.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module json_stream_tokenizer_core
  import jst_pkg::*;
#(
  parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire jst_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output jst_out_t        out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [5:0] cfg_data
);

  localparam int LW = $clog2(MAX_DEPTH + 1);

  logic          in_valid_r;
  jst_in_t       in_word_r;
  logic          out_valid_r;
  jst_out_t      out_word_r;
  logic [5:0]    depth_limit_r;
  jst_state_t    st_r;
  jst_state_t    st_nxt;
  logic [LW-1:0] level_r;
  logic [LW-1:0] level_nxt;
  jst_stack_op_t op;
  jst_out_t      res;
  logic          top_obj;
  logic          below_obj;
  logic          step;

  assign step      = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || step;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      depth_limit_r <= DEPTH_LIMIT_RESET;
      level_r       <= '0;
      st_r          <= '{expect_mask: EX_ARR | EX_OBJ | EX_VAL, mode: M_IDLE,
                         in_obj: 1'b0, in_key: 1'b0, in_arr: 1'b0, lit_pos: 3'd0,
                         esc: 1'b0, err: ERR_NONE, line: 16'd1};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (step) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
        level_r     <= level_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        depth_limit_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
    if (step) begin
      out_word_r <= res;
    end
  end

  jst_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (step),
    .op        (op),
    .top_obj   (top_obj),
    .below_obj (below_obj)
  );

  jst_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .LW        (LW)
  ) u_step (
    .st          (st_r),
    .level       (level_r),
    .top_obj     (top_obj),
    .below_obj   (below_obj),
    .depth_limit (depth_limit_r),
    .word        (in_word_r),
    .st_nxt      (st_nxt),
    .level_nxt   (level_nxt),
    .op          (op),
    .res         (res)
  );

  `ASSERT_ALWAYS(a_level_bound, clk, rst_n, level_r <= LW'(MAX_DEPTH))
  `ASSERT_NEXT(a_err_sticky, clk, rst_n, st_r.err != ERR_NONE && !(step && in_word_r.end_of_doc), st_r.err == $past(st_r.err))
  `ASSERT_IMPLY(a_err_no_event, clk, rst_n, out_valid_r && out_word_r.error_code != ERR_NONE, out_word_r.event_res == EV_NONE)
  `ASSERT_IMPLY(a_unbal_at_end, clk, rst_n, out_valid_r && out_word_r.unbalanced, out_word_r.doc_done)

endmodule

`default_nettype wire

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// JSON stream tokenizer testbench
// Streams directed and random documents through the tokenizer, predicts every
// token word in a behavioral model of the validator and compares field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import jst_pkg::*;

  localparam logic [3:0] EV_FALSE = 4'd13;
  localparam logic [3:0] EV_NULL  = 4'd14;
  localparam int         LIMIT    = 400000;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  jst_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  jst_out_t out_data;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [5:0] cfg_data;

  json_stream_tokenizer_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Predictor state.
  logic [5:0]  p_limit;
  logic        p_stack [32];
  int          p_level;
  logic [6:0]  p_mask;
  logic [2:0]  p_mode;
  logic        p_obj, p_key, p_arr;
  int          p_pos;
  logic        p_esc;
  logic [2:0]  p_err;
  int          p_line;
  logic [3:0]  p_ev;
  logic [7:0]  p_data;

  jst_out_t token_queue[$];
  int       fail_count;
  int       cycle_count;
  int       burst_left;
  int       gap_left;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("Mismatch at cycle %0d: %s", cycle_count, msg);
    fail_count++;
  endtask

  function automatic void tok_fail(input logic [2:0] code);
    if (p_err == ERR_NONE) p_err = code;
  endfunction

  function automatic logic top_obj();
    if (p_level == 0) return 1'b0;
    return p_stack[p_level - 1];
  endfunction

  function automatic void value_done();
    if (p_key) begin
      p_mask = EX_COLON;
      p_key = 1'b0;
    end else if (p_level == 0) begin
      p_mask = '0;
    end else begin
      p_mask = EX_COMMA | (top_obj() ? EX_OBJ_END : EX_ARR_END);
    end
  endfunction

  function automatic void tok_state_clear();
    for (int i = 0; i < 32; i++) p_stack[i] = 1'b0;
    p_level = 0;
    p_mask = EX_ARR | EX_OBJ | EX_VAL;
    p_mode = M_IDLE;
    p_obj = 1'b0;
    p_key = 1'b0;
    p_arr = 1'b0;
    p_pos = 0;
    p_esc = 1'b0;
    p_err = ERR_NONE;
    p_line = 1;
  endfunction

  function automatic logic value_ok(input logic is_str);
    if (!(p_mask & EX_VAL) || (p_key && !is_str)) begin
      tok_fail(ERR_TOKEN);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void open_cont(input logic obj);
    int lim;
    lim = (p_limit > 32) ? 32 : p_limit;
    if (!(p_mask & (obj ? EX_OBJ : EX_ARR))) begin
      tok_fail(ERR_TOKEN);
      return;
    end
    if (p_level >= lim) begin
      tok_fail(ERR_DEPTH);
      return;
    end
    p_stack[p_level] = obj;
    p_level++;
    p_obj = obj;
    p_arr = !obj;
    p_key = obj;
    p_mask = obj ? (EX_VAL | EX_OBJ_END) : (EX_VAL | EX_ARR | EX_OBJ | EX_ARR_END);
    p_ev = obj ? EV_OBJ_OPN : EV_ARR_OPN;
  endfunction

  function automatic void close_cont(input logic obj);
    if (!(p_mask & (obj ? EX_OBJ_END : EX_ARR_END)) || p_level == 0) begin
      tok_fail(ERR_TOKEN);
      return;
    end
    p_level--;
    p_key = 1'b0;
    if (p_level == 0) begin
      p_obj = 1'b0;
      p_arr = 1'b0;
      p_mask = '0;
    end else begin
      p_obj = top_obj();
      p_arr = !p_obj;
      p_mask = EX_COMMA | (p_obj ? EX_OBJ_END : EX_ARR_END);
    end
    p_ev = obj ? EV_OBJ_CLS : EV_ARR_CLS;
  endfunction

  function automatic void idle_char(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR: ;
      CH_LF: if (p_line < 65535) p_line++;
      CH_LBRK: open_cont(1'b0);
      CH_LBRC: open_cont(1'b1);
      CH_RBRK: close_cont(1'b0);
      CH_RBRC: close_cont(1'b1);
      CH_COMMA: begin
        if (!p_arr && !p_obj) tok_fail(ERR_SEP);
        else if (!(p_mask & EX_COMMA)) tok_fail(ERR_TOKEN);
        else begin
          if (p_arr) p_mask = EX_VAL | EX_ARR | EX_OBJ;
          else begin
            p_mask = EX_VAL | EX_OBJ_END;
            p_key = 1'b1;
          end
          p_ev = EV_COMMA;
        end
      end
      CH_COLON: begin
        if (!(p_mask & EX_COLON)) tok_fail(ERR_TOKEN);
        else begin
          p_mask = EX_VAL | EX_ARR | EX_OBJ;
          p_key = 1'b0;
          p_ev = EV_COLON;
        end
      end
      CH_QUOTE: begin
        if (value_ok(1'b1)) begin
          p_mode = p_key ? M_KEY : M_STR;
          p_esc = 1'b0;
        end
      end
      CH_LC_T, CH_LC_F, CH_LC_N: begin
        if (value_ok(1'b0)) begin
          p_mode = (c == CH_LC_T) ? M_TRUE : ((c == CH_LC_F) ? M_FALSE : M_NULL);
          p_pos = 1;
        end
      end
      default: begin
        if (c == CH_MINUS || (c >= CH_ZERO && c <= CH_NINE)) begin
          if (value_ok(1'b0)) begin
            p_mode = M_NUM;
            p_pos = (c == CH_MINUS) ? 0 : 1;
            p_ev = EV_NUMBYTE;
            p_data = c;
          end
        end else begin
          tok_fail(ERR_CHAR);
        end
      end
    endcase
  endfunction

  function automatic void string_char(input logic [7:0] c);
    logic       is_key;
    logic [7:0] d;
    is_key = (p_mode == M_KEY);
    if (p_esc) begin
      case (c)
        CH_QUOTE, CH_BSL, CH_SLASH: d = c;
        CH_LC_B: d = 8'h08;
        CH_LC_F: d = 8'h0C;
        CH_LC_N: d = 8'h0A;
        CH_LC_R: d = 8'h0D;
        CH_LC_T: d = 8'h09;
        default: begin
          tok_fail(ERR_ESCAPE);
          return;
        end
      endcase
      p_esc = 1'b0;
      p_ev = is_key ? EV_KEYBYTE : EV_STRBYTE;
      p_data = d;
    end else if (c == CH_BSL) begin
      p_esc = 1'b1;
    end else if (c == CH_QUOTE) begin
      p_mode = M_IDLE;
      p_ev = is_key ? EV_KEYEND : EV_STREND;
      value_done();
    end else begin
      p_ev = is_key ? EV_KEYBYTE : EV_STRBYTE;
      p_data = c;
    end
  endfunction

  function automatic void literal_char(input logic [7:0] c);
    string txt;
    int    which;
    which = p_mode - M_TRUE;
    txt = (which == 0) ? "true" : ((which == 1) ? "false" : "null");
    if (p_pos >= txt.len() || txt[p_pos] != c) begin
      tok_fail(ERR_LITERAL);
      return;
    end
    p_pos++;
    if (p_pos == txt.len()) begin
      p_ev = EV_TRUE + which;
      p_mode = M_IDLE;
      p_pos = 0;
      value_done();
    end
  endfunction

  function automatic jst_out_t predict_token(input jst_in_t w);
    jst_out_t   r;
    logic [7:0] c;
    logic       ndone;
    c = w.end_of_doc ? CH_LF : w.in_byte;
    ndone = 1'b0;
    p_ev = EV_NONE;
    p_data = '0;
    if (p_err == ERR_NONE) begin
      if (p_mode == M_STR || p_mode == M_KEY) begin
        string_char(c);
      end else if (p_mode == M_NUM) begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          p_pos = 1;
          p_ev = EV_NUMBYTE;
          p_data = c;
        end else if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_LBRK, CH_RBRK,
                               CH_LBRC, CH_RBRC, CH_COLON, CH_COMMA}) begin
          if (p_pos == 0) tok_fail(ERR_CHAR);
          else begin
            ndone = 1'b1;
            p_mode = M_IDLE;
            p_pos = 0;
            value_done();
            idle_char(c);
          end
        end else begin
          tok_fail(ERR_CHAR);
        end
      end else if (p_mode >= M_TRUE && p_mode <= M_NULL) begin
        literal_char(c);
      end else begin
        idle_char(c);
      end
    end
    if (p_err != ERR_NONE) begin
      p_ev = EV_NONE;
      p_data = '0;
    end
    r.event_res   = p_ev;
    r.data_byte   = p_data;
    r.number_done = ndone;
    r.nest_depth  = p_level[5:0];
    r.error_code  = p_err;
    r.line_number = p_line[15:0];
    r.doc_done    = w.end_of_doc;
    r.unbalanced  = w.end_of_doc && p_level != 0;
    if (w.end_of_doc) tok_state_clear();
    return r;
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eod);
    jst_in_t w;
    w.in_byte = b;
    w.end_of_doc = eod;
    if (burst_left == 0) begin
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      burst_left = $urandom_range(1, 20);
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        repeat (gap_left) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= w;
    token_queue.push_back(predict_token(w));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  task automatic end_doc();
    send_word($urandom_range(0, 255), 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (token_queue.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [5:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_limit = v;
  endtask

  task automatic test_directed();
    send_text("{\"a\\n\\t\\\"\\/\\\\\\b\\f\\r\":[1,-20,007 ,true,false,null,{},[]],\"k\":\"x\",}");
    end_doc();
    send_text("[[]"); end_doc();
    send_text("]"); end_doc();
    send_text("[}"); end_doc();
    send_text(","); end_doc();
    send_text(":"); end_doc();
    send_text("{1:2}"); end_doc();
    send_text("[- ]"); end_doc();
    send_text("\"\\u0\""); end_doc();
    send_text("\"\\q\""); end_doc();
    send_text("1 2"); end_doc();
    send_text("tru "); end_doc();
    send_text("[\"open"); end_doc();
    send_text("nul"); end_doc();
    send_text("\n\n[\x00\xff]"); end_doc();
    send_text("-5}"); end_doc();
  endtask

  task automatic test_depth(input logic [5:0] lim);
    write_limit(lim);
    for (int i = 0; i <= lim && i < 34; i++) send_text((i % 2) ? "{\"k\":" : "[");
    end_doc();
    send_text("[{}]"); end_doc();
  endtask

  function automatic string rand_value(input int depth);
    string s;
    int    n;
    case ($urandom_range(0, 9))
      0: return "true";
      1: return "false";
      2: return "null";
      3, 4: begin
        s = ($urandom_range(0, 1) ? "-" : "");
        n = $urandom_range(1, 4);
        repeat (n) s = {s, string'(8'h30 + $urandom_range(0, 9))};
        return s;
      end
      5, 6: begin
        s = "\"";
        n = $urandom_range(0, 4);
        repeat (n) begin
          case ($urandom_range(0, 5))
            0: s = {s, "\\n"};
            1: s = {s, "\\\""};
            default: s = {s, string'(8'h61 + $urandom_range(0, 25))};
          endcase
        end
        return {s, "\""};
      end
      7: begin
        if (depth > 3) return "0";
        s = "[";
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) s = {s, (i ? ", " : ""), rand_value(depth + 1)};
        return {s, "]"};
      end
      default: begin
        if (depth > 3) return "null";
        s = "{";
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
          s = {s, (i ? ",\n" : ""), "\"k", string'(8'h30 + i), "\":", rand_value(depth + 1)};
        return {s, ($urandom_range(0, 5) == 0 && n > 0) ? ",}" : "}"};
      end
    endcase
  endfunction

  task automatic test_random(input int words);
    string s;
    int    sent;
    sent = 0;
    while (sent < words) begin
      s = rand_value(0);
      if ($urandom_range(0, 4) == 0) begin
        s[$urandom_range(0, s.len() - 1)] = $urandom_range(0, 255);
      end
      if ($urandom_range(0, 9) == 0) s = s.substr(0, $urandom_range(0, s.len() - 1));
      send_text(s);
      if ($urandom_range(0, 3) == 0) send_text(" \r\t\n");
      end_doc();
      sent += s.len() + 1;
    end
  endtask

  always @(posedge clk) begin
    jst_out_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 7) != 0) || (cycle_count[9:8] == 2'b00);
      if (out_valid && out_ready) begin
        if (token_queue.size() == 0) begin
          report("token word with no expectation");
        end else begin
          e = token_queue.pop_front();
          if (out_data.event_res != e.event_res) report("event_res");
          if (out_data.data_byte != e.data_byte) report("data_byte");
          if (out_data.number_done != e.number_done) report("number_done");
          if (out_data.nest_depth != e.nest_depth) report("nest_depth");
          if (out_data.error_code != e.error_code) report("error_code");
          if (out_data.line_number != e.line_number) report("line_number");
          if (out_data.doc_done != e.doc_done) report("doc_done");
          if (out_data.unbalanced != e.unbalanced) report("unbalanced");
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    cycle_count = 0;
    fail_count = 0;
    burst_left = 0;
    gap_left = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    p_limit = DEPTH_LIMIT_RESET;
    tok_state_clear();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_depth(6'd1);
    test_depth(6'd0);
    test_depth(6'd63);
    test_depth(6'd3);
    write_limit(6'd32);
    test_depth(6'd32);
    write_limit(6'd5);
    test_random(400);
    write_limit(6'd32);
    test_random(600);
    drain();
    if (token_queue.size() != 0) report("expectations left over");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
